@@ src/apf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_pkg: shared types and codes for the cut vertex finder
// Command codes, sequencer states and the control bundle into the adjacency
// store.
// ----------------------------------------------------------------------------
package apf_pkg;

   // command codes on req_func
   localparam logic [1:0] FUNC_ADD     = 2'd0;
   localparam logic [1:0] FUNC_COMPUTE = 2'd1;
   localparam logic [1:0] FUNC_CLEAR   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_INIT,
      ST_ROOT,
      ST_FETCH,
      ST_READ,
      ST_SCAN,
      ST_NEIGH,
      ST_POP,
      ST_MERGE,
      ST_COUNT,
      ST_EMIT
   } state_type;

   // request into the adjacency store
   typedef struct packed {
      logic       wr_edge;
      logic       clr_row;
      logic [5:0] row_a;
      logic [5:0] row_b;
      logic [5:0] rd_row;
   } adj_ctl_type;

endpackage

@@ src/apf_adj_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apf_adj_mem: adjacency bit matrix
// One row per vertex; symmetric edge set, row clear sweep, registered read.
// ----------------------------------------------------------------------------
module apf_adj_mem
   import apf_pkg::*;
(
   input  logic        clock,
   input  adj_ctl_type ctl,
   output logic [63:0] rd_row_ff
);

   logic [63:0] mem [64];

   // edge set is done as two row updates from the same request; rows hold
   // flip-flops so each row can take its own bit
   always_ff @(posedge clock) begin
      for (int i = 0; i < 64; i++) begin
         if (ctl.clr_row && ctl.row_a == 6'(i)) begin
            mem[i] <= '0;
         end else if (ctl.wr_edge) begin
            if (ctl.row_a == 6'(i)) mem[i][ctl.row_b] <= 1'b1;
            if (ctl.row_b == 6'(i)) mem[i][ctl.row_a] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_row_ff <= mem[ctl.rd_row];
   end

endmodule

@@ src/articulation_point_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// articulation_point_finder: cut vertices of an undirected graph
// Edge loading, depth-first walk with explicit stack, ascending emission.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: req_start with req_func/req_vertex_a/req_vertex_b,
//   transfer when req_start is high and busy is low.
//   Add edge: busy stays low, edges can follow back to back; no result.
//   Clear graph: a row sweep over all 64 rows with busy high, no result.
//   Compute: each stack step fetches the stack top (registered stores), then
//   scans its adjacency row one entry per cycle, leaving the scan at each
//   neighbor found. The walk is followed by a count pass and an emission
//   pass; busy is high throughout and one command is in flight at a time.
//   Results: rsp_valid pulses for one cycle per cut vertex in ascending
//   order, rsp_last on the final one; with no cut vertex the answer is one
//   item with rsp_cut_vertex 0. The receiver cannot stall.
//   csr_wr_en/csr_wr_data write vertex_count; the user must write it only while idle, the block does not enforce this.
//   Reset: vertex_count 64, then a clearing pass over all 64 rows empties
//   the graph with busy high.
// ----------------------------------------------------------------------------
module articulation_point_finder
   import apf_pkg::*;
#(
   parameter int MAX_VERTICES = 64
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_start,
   input  logic [1:0] req_func,
   input  logic [6:0] req_vertex_a,
   input  logic [6:0] req_vertex_b,
   output logic       busy,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data,
   output logic       rsp_valid,
   output logic [6:0] rsp_cut_vertex,
   output logic [5:0] rsp_cut_total,
   output logic       rsp_last
);

   localparam logic [6:0] MaxV = 7'(MAX_VERTICES);

   state_type   state_ff, state_in;
   logic [6:0]  vcount_ff;
   logic [63:0] row;
   adj_ctl_type actl;

   logic [63:0] visited_ff, cut_ff;
   logic [6:0]  disc [64];
   logic [6:0]  lowl [64];
   logic [5:0]  stk_v [64];
   logic [6:0]  stk_c [64];
   logic [6:0]  sp_ff;
   logic [6:0]  root_ch_ff;
   logic [6:0]  time_ff;
   logic [6:0]  vi_ff;      // clear / root / count / emit index
   logic [6:0]  u_ff;       // neighbor cursor
   logic [5:0]  total_ff, k_ff;
   logic [6:0]  n_eff;
   logic        fresh_ff;   // stack top just pushed, cursor starts at 0

   // registered read data of the walk stores
   logic [5:0]  top_v_ff, par_v_ff;
   logic [6:0]  cur_c_ff;
   logic [6:0]  disc_rd_ff;
   logic [6:0]  low_top_ff, low_par_ff;

   // effective vertex count
   always_comb begin
      if (vcount_ff == 7'd0) n_eff = 7'd1;
      else if (vcount_ff > MaxV) n_eff = MaxV;
      else n_eff = vcount_ff;
   end

   logic [6:0] top_i;
   logic [5:0] par_i;
   logic       par_known;
   logic [5:0] disc_addr;
   assign top_i     = sp_ff - 7'd1;
   assign par_i     = 6'(top_i - 7'd1);
   assign par_known = top_i != 7'd0;
   // neighbor discovery time while scanning, parent's once the row is done
   assign disc_addr = (state_ff == ST_SCAN && u_ff < n_eff) ? u_ff[5:0] : par_v_ff;

   logic       edge_ok;
   assign edge_ok = req_vertex_a >= 7'd1 && req_vertex_a <= MaxV &&
                    req_vertex_b >= 7'd1 && req_vertex_b <= MaxV;

   logic       take;
   assign take = req_start && !busy;
   assign busy = state_ff != ST_IDLE;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take && req_func == FUNC_COMPUTE) state_in = ST_INIT;
            else if (take && req_func == FUNC_CLEAR) state_in = ST_CLEAR;
         end
         ST_CLEAR: if (vi_ff == 7'd63) state_in = ST_IDLE;
         ST_INIT:  state_in = ST_ROOT;
         ST_ROOT: begin
            if (vi_ff >= n_eff) state_in = ST_COUNT;
            else if (!visited_ff[vi_ff[5:0]]) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_READ;
         ST_READ:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (u_ff >= n_eff) state_in = ST_POP;
            else if (row[u_ff[5:0]]) state_in = ST_NEIGH;
         end
         ST_NEIGH: state_in = ST_FETCH;
         ST_POP:   state_in = ST_MERGE;
         ST_MERGE: state_in = (sp_ff == 7'd0) ? ST_ROOT : ST_FETCH;
         ST_COUNT: if (vi_ff >= n_eff) state_in = ST_EMIT;
         ST_EMIT: begin
            if (total_ff == 6'd0 || vi_ff >= n_eff || (rsp_valid && rsp_last))
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // adjacency store control
   always_comb begin
      actl.wr_edge = state_ff == ST_IDLE && take && req_func == FUNC_ADD && edge_ok;
      actl.clr_row = state_ff == ST_CLEAR;
      actl.row_a   = (state_ff == ST_CLEAR) ? vi_ff[5:0] : 6'(req_vertex_a - 7'd1);
      actl.row_b   = 6'(req_vertex_b - 7'd1);
      actl.rd_row  = top_v_ff;
   end

   apf_adj_mem u_adj (
      .clock     (clock),
      .ctl       (actl),
      .rd_row_ff (row)
   );

   // outputs
   always_comb begin
      rsp_valid      = 1'b0;
      rsp_cut_vertex = 7'd0;
      rsp_cut_total  = total_ff;
      rsp_last       = 1'b0;
      if (state_ff == ST_EMIT) begin
         if (total_ff == 6'd0) begin
            rsp_valid = 1'b1;
            rsp_last  = 1'b1;
         end else if (vi_ff < n_eff && cut_ff[vi_ff[5:0]]) begin
            rsp_valid      = 1'b1;
            rsp_cut_vertex = vi_ff + 7'd1;
            rsp_last       = (k_ff + 6'd1) == total_ff;
         end
      end
   end

   // control registers; reset starts with a clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         vcount_ff <= 7'd64;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) vcount_ff <= csr_wr_data;
      end
   end

   // walk store reads, one clocked read per port
   always_ff @(posedge clock) begin
      top_v_ff   <= stk_v[top_i[5:0]];
      par_v_ff   <= stk_v[par_i];
      cur_c_ff   <= stk_c[top_i[5:0]];
      disc_rd_ff <= disc[disc_addr];
      low_top_ff <= lowl[top_v_ff];
      low_par_ff <= lowl[par_v_ff];
   end

   // walk datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= 7'd0;
         vi_ff <= 7'd0;
      end else begin
         case (state_ff)
            ST_IDLE: vi_ff <= 7'd0;
            ST_CLEAR: vi_ff <= vi_ff + 7'd1;
            ST_INIT: begin
               visited_ff <= '0;
               cut_ff     <= '0;
               time_ff    <= 7'd0;
               vi_ff      <= 7'd0;
               total_ff   <= 6'd0;
               k_ff       <= 6'd0;
            end
            ST_ROOT: begin
               if (vi_ff < n_eff) begin
                  if (!visited_ff[vi_ff[5:0]]) begin
                     visited_ff[vi_ff[5:0]] <= 1'b1;
                     disc[vi_ff[5:0]]       <= time_ff;
                     lowl[vi_ff[5:0]]       <= time_ff;
                     time_ff                <= time_ff + 7'd1;
                     stk_v[0]               <= vi_ff[5:0];
                     fresh_ff               <= 1'b1;
                     sp_ff                  <= 7'd1;
                     root_ch_ff             <= 7'd0;
                  end else begin
                     vi_ff <= vi_ff + 7'd1;
                  end
               end else begin
                  vi_ff <= 7'd0;
               end
            end
            ST_READ: begin
               u_ff     <= fresh_ff ? 7'd0 : cur_c_ff;
               fresh_ff <= 1'b0;
            end
            ST_SCAN: begin
               if (u_ff < n_eff && !row[u_ff[5:0]]) u_ff <= u_ff + 7'd1;
            end
            ST_NEIGH: begin
               stk_c[top_i[5:0]] <= u_ff + 7'd1;
               if (!(par_known && u_ff[5:0] == par_v_ff)) begin
                  if (visited_ff[u_ff[5:0]]) begin
                     if (disc_rd_ff < low_top_ff) lowl[top_v_ff] <= disc_rd_ff;
                  end else begin
                     if (top_i == 7'd0) root_ch_ff <= root_ch_ff + 7'd1;
                     visited_ff[u_ff[5:0]] <= 1'b1;
                     disc[u_ff[5:0]]       <= time_ff;
                     lowl[u_ff[5:0]]       <= time_ff;
                     time_ff               <= time_ff + 7'd1;
                     stk_v[sp_ff[5:0]]     <= u_ff[5:0];
                     fresh_ff              <= 1'b1;
                     sp_ff                 <= sp_ff + 7'd1;
                  end
               end
            end
            ST_POP: begin
               if (par_known) begin
                  if (low_top_ff < low_par_ff) lowl[par_v_ff] <= low_top_ff;
                  if (top_i > 7'd1 && low_top_ff >= disc_rd_ff) cut_ff[par_v_ff] <= 1'b1;
               end
               sp_ff <= sp_ff - 7'd1;
            end
            ST_MERGE: begin
               if (sp_ff == 7'd0) begin
                  if (root_ch_ff > 7'd1) cut_ff[vi_ff[5:0]] <= 1'b1;
                  vi_ff <= vi_ff + 7'd1;
               end
            end
            ST_COUNT: begin
               if (vi_ff < n_eff) begin
                  if (cut_ff[vi_ff[5:0]]) total_ff <= total_ff + 6'd1;
                  vi_ff <= vi_ff + 7'd1;
               end else begin
                  vi_ff <= 7'd0;
               end
            end
            ST_EMIT: begin
               vi_ff <= vi_ff + 7'd1;
               if (rsp_valid) k_ff <= k_ff + 6'd1;
            end
            default: vi_ff <= vi_ff;
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   // results appear only during the emission pass
   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_EMIT)
      else $error("result outside emission");

   // the last result ends the run
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> state_ff == ST_IDLE)
      else $error("run continues after last result");

   // the stack never overflows
   a_stack: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= 7'd64)
      else $error("stack overflow");
`endif

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for articulation_point_finder
// Loads random and directed graphs edge by edge and issues compute and clear
// commands at several vertex counts. A scoreboard class keeps its own
// adjacency matrix, runs a depth-first cut vertex search on every compute
// and checks each emitted result field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
   import apf_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [6:0] cut_vertex;
      logic [5:0] cut_total;
      logic       last;
   } cut_result_type;

   // --------------------------------------------------------------------------
   // scoreboard: graph shadow, cut vertex search, ordered result check
   // --------------------------------------------------------------------------
   class cut_scoreboard;
      bit [63:0]      adj [64];
      logic [6:0]     vcount;
      cut_result_type pending [$];
      int             mismatches;
      int             checked;
      int             computes;
      // per-walk working state
      bit             seen [64];
      bit             is_cut [64];
      logic [6:0]     disc [64];
      logic [6:0]     low [64];
      int             stk_v [64];
      int             stk_cur [64];
      int             sp;
      logic [6:0]     clock_tick;

      function void reset_state();
         foreach (adj[i]) adj[i] = '0;
         vcount = 7'd64;
         pending.delete();
         mismatches = 0;
         checked = 0;
         computes = 0;
      endfunction

      function void push_vertex(int v);
         seen[v] = 1'b1;
         disc[v] = clock_tick;
         low[v] = clock_tick;
         clock_tick = clock_tick + 7'd1;
         stk_v[sp] = v;
         stk_cur[sp] = 0;
         sp++;
      endfunction

      // depth-first search over vertices 0..n-1, fills is_cut
      function void find_cuts(int n);
         int top, v, par, u, root_kids;
         bit has_par;
         foreach (seen[i]) begin
            seen[i] = 1'b0;
            is_cut[i] = 1'b0;
         end
         clock_tick = '0;
         for (int r = 0; r < n; r++) begin
            if (seen[r]) continue;
            sp = 0;
            root_kids = 0;
            push_vertex(r);
            while (sp > 0) begin
               top = sp - 1;
               v = stk_v[top];
               has_par = (top > 0);
               par = has_par ? stk_v[top - 1] : 64;
               u = stk_cur[top];
               while (u < n && !adj[v][u]) u++;
               if (u < n) begin
                  stk_cur[top] = u + 1;
                  if (u != par) begin
                     if (seen[u]) begin
                        if (disc[u] < low[v]) low[v] = disc[u];
                     end else begin
                        if (top == 0) root_kids++;
                        push_vertex(u);
                     end
                  end
               end else begin
                  sp--;
                  if (has_par) begin
                     if (low[v] < low[par]) low[par] = low[v];
                     if (top - 1 > 0 && low[v] >= disc[par]) is_cut[par] = 1'b1;
                  end
               end
            end
            if (root_kids > 1) is_cut[r] = 1'b1;
         end
      endfunction

      // note one accepted command and queue what it should produce
      function void note_request(logic [1:0] func, logic [6:0] a, logic [6:0] b);
         int n, total, k;
         cut_result_type res;
         case (func)
            FUNC_ADD: begin
               if (a >= 1 && a <= 64 && b >= 1 && b <= 64) begin
                  adj[a - 1][b - 1] = 1'b1;
                  adj[b - 1][a - 1] = 1'b1;
               end
            end
            FUNC_CLEAR: foreach (adj[i]) adj[i] = '0;
            FUNC_COMPUTE: begin
               computes++;
               n = (vcount < 1) ? 1 : (vcount > 64) ? 64 : int'(vcount);
               find_cuts(n);
               total = 0;
               for (int v = 0; v < n; v++) if (is_cut[v]) total++;
               if (total == 0) begin
                  res.cut_vertex = '0;
                  res.cut_total = '0;
                  res.last = 1'b1;
                  pending.insert(pending.size(), res);
               end else begin
                  k = 0;
                  for (int v = 0; v < n && k < 62; v++) begin
                     if (is_cut[v]) begin
                        res.cut_vertex = 7'(v + 1);
                        res.cut_total = 6'(total);
                        res.last = (k + 1 == total);
                        pending.insert(pending.size(), res);
                        k++;
                     end
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [6:0] cv, logic [5:0] ct, logic lst);
         cut_result_type exp_res;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result vertex=%0d total=%0d last=%0b",
                        $realtime, cv, ct, lst);
            return;
         end
         exp_res = pending.pop_front();
         checked++;
         if (cv !== exp_res.cut_vertex || ct !== exp_res.cut_total ||
             lst !== exp_res.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: mismatch exp v=%0d t=%0d l=%0b got v=%0d t=%0d l=%0b",
                        $realtime, exp_res.cut_vertex, exp_res.cut_total,
                        exp_res.last, cv, ct, lst);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_start = 1'b0;
   logic [1:0] req_func = FUNC_ADD;
   logic [6:0] req_vertex_a = '0;
   logic [6:0] req_vertex_b = '0;
   logic       busy;
   logic       csr_wr_en = 1'b0;
   logic [6:0] csr_wr_data = '0;
   logic       rsp_valid;
   logic [6:0] rsp_cut_vertex;
   logic [5:0] rsp_cut_total;
   logic       rsp_last;

   cut_scoreboard sb;
   int  transfers;
   int  items;
   bit  allow_gaps;

   articulation_point_finder dut (
      .clock          (clock),
      .reset          (reset),
      .req_start      (req_start),
      .req_func       (req_func),
      .req_vertex_a   (req_vertex_a),
      .req_vertex_b   (req_vertex_b),
      .busy           (busy),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .rsp_valid      (rsp_valid),
      .rsp_cut_vertex (rsp_cut_vertex),
      .rsp_cut_total  (rsp_cut_total),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result(rsp_cut_vertex, rsp_cut_total, rsp_last);
         transfers++;
      end
   end

   // watchdog: cycles without any transfer
   initial begin
      int quiet, seen_xfers;
      quiet = 0;
      seen_xfers = 0;
      forever begin
         @(negedge clock);
         if (transfers != seen_xfers || reset) begin
            seen_xfers = transfers;
            quiet = 0;
         end else if (++quiet >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet);
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // one command transfer; called and returns at a falling edge
   task automatic send_cmd(logic [1:0] func, logic [6:0] a, logic [6:0] b);
      if (allow_gaps && $urandom_range(99) < 30)
         repeat ($urandom_range(1, 4)) @(negedge clock);
      req_start = 1'b1;
      req_func = func;
      req_vertex_a = a;
      req_vertex_b = b;
      // busy only moves at rising edges, so its value here holds at the next one
      while (busy) @(negedge clock);
      @(posedge clock);
      sb.note_request(func, a, b);
      transfers++;
      items++;
      @(negedge clock);
      req_start = 1'b0;
   endtask

   // vertex count write once everything has drained
   task automatic write_vertex_count(logic [6:0] val);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.vcount = val;
   endtask

   initial begin
      int vc, span, n_edges;
      sb = new();
      sb.reset_state();
      transfers = 0;
      items = 0;
      allow_gaps = 1'b1;
      repeat (11) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: path, top vertex, ignored endpoints, loops, unused code
      send_cmd(FUNC_ADD, 7'd1, 7'd2);
      send_cmd(FUNC_ADD, 7'd2, 7'd3);
      send_cmd(FUNC_COMPUTE, 7'd0, 7'd0);
      send_cmd(FUNC_ADD, 7'd64, 7'd10);
      send_cmd(FUNC_ADD, 7'd63, 7'd64);
      send_cmd(FUNC_COMPUTE, 7'd127, 7'd127);
      send_cmd(FUNC_ADD, 7'd0, 7'd5);
      send_cmd(FUNC_ADD, 7'd5, 7'd127);
      send_cmd(FUNC_ADD, 7'd65, 7'd1);
      send_cmd(FUNC_ADD, 7'd3, 7'd3);
      send_cmd(FUNC_ADD, 7'd2, 7'd1);
      send_cmd(FUNC_UNUSED, 7'd4, 7'd6);
      send_cmd(FUNC_COMPUTE, 7'd0, 7'd0);
      send_cmd(FUNC_CLEAR, 7'd0, 7'd0);
      send_cmd(FUNC_COMPUTE, 7'd0, 7'd0);
      // edges past the vertex count stay stored but are not walked
      write_vertex_count(7'd3);
      send_cmd(FUNC_ADD, 7'd1, 7'd2);
      send_cmd(FUNC_ADD, 7'd2, 7'd3);
      send_cmd(FUNC_ADD, 7'd3, 7'd4);
      send_cmd(FUNC_COMPUTE, 7'd0, 7'd0);
      write_vertex_count(7'd0);
      send_cmd(FUNC_COMPUTE, 7'd0, 7'd0);
      write_vertex_count(7'd127);
      send_cmd(FUNC_COMPUTE, 7'd0, 7'd0);
      write_vertex_count(7'd1);
      send_cmd(FUNC_COMPUTE, 7'd0, 7'd0);

      // random graphs: mostly small, a few at the full size
      while (items < 240) begin
         allow_gaps = !(items > 120 && items < 180);
         case ($urandom_range(9))
            0: vc = 64;
            1: vc = 127;
            2: vc = $urandom_range(0, 1);
            3: vc = $urandom_range(13, 126);
            default: vc = $urandom_range(2, 12);
         endcase
         write_vertex_count(7'(vc));
         send_cmd(FUNC_CLEAR, 7'($urandom_range(127)), 7'($urandom_range(127)));
         span = (vc < 1) ? 2 : (vc >= 64) ? 64 : vc + 1;
         n_edges = $urandom_range(0, (span > 12) ? 14 : 2 * span);
         for (int e = 0; e < n_edges; e++) begin
            if ($urandom_range(99) < 85)
               send_cmd(FUNC_ADD, 7'($urandom_range(1, span)), 7'($urandom_range(1, span)));
            else
               send_cmd($urandom_range(9) == 0 ? FUNC_UNUSED : FUNC_ADD,
                        7'($urandom_range(127)), 7'($urandom_range(127)));
         end
         send_cmd(FUNC_COMPUTE, 7'($urandom_range(127)), 7'($urandom_range(127)));
         if ($urandom_range(3) == 0)
            send_cmd(FUNC_COMPUTE, 7'($urandom_range(127)), 7'($urandom_range(127)));
      end

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("covered %0d commands, %0d compute runs, %0d cut vertex results checked",
               items, sb.computes, sb.checked);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
